/* hw/rtl/mlp_pkg.sv */
`default_nettype none
package mlp_pkg;

	localparam int ACC_W   = 40;
	localparam int VAL_W   = 16;
	localparam int PIX_W   = 8;
	localparam int IDX_W   = 4;
	localparam int SCORE_W = 32;
	localparam int SHIFT_W = 4;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;

	typedef enum logic [2:0] {
		OP_HW  = 3'd0,
		OP_HB  = 3'd1,
		OP_OW  = 3'd2,
		OP_OB  = 3'd3,
		OP_PIX = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX,
		ST_ACT,
		ST_LOGIT,
		ST_DRAIN
	} seq_state_t;

	typedef enum logic [1:0] {
		PASS_PIX,
		PASS_ACT,
		PASS_LOGIT
	} pass_t;

	typedef struct packed {
		logic             v;
		pass_t            kind;
		logic             first_h;
		logic             last_h;
		logic             final_c;
		logic [IDX_W-1:0] cls;
	} tag_t;

endpackage
`default_nettype wire

/* hw/rtl/mlp_ram.sv */
`default_nettype none
module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/mlp_cell.sv */
`default_nettype none
module mlp_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic [mlp_pkg::ACC_W-1:0] d,
	output logic      [mlp_pkg::ACC_W-1:0] q
);
	import mlp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= d;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mlp_two_layer_inference_core.sv */
// Load items leave busy low.
// A pixel item with an address below INPUT_COUNT holds busy while the ring of hidden cells turns once.
// A last pixel adds an activation pass over the hidden cells and a logit pass over every class and
// hidden cell, one store read per cycle; the final read passes the s1, s2, s3 and s4 stages to strobe.
// The receiver cannot stall; a result is shown for exactly one cycle.
// Reset clears the hidden sums and sets frac_q to 8; weight stores are undefined.
`default_nettype none
module mlp_two_layer_inference_core #(
	parameter int INPUT_COUNT  = 784,
	parameter int HIDDEN_COUNT = 100,
	parameter int CLASS_COUNT  = 10,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [2:0]                          op,
	input  wire logic [16:0]                         addr,
	input  wire logic signed [mlp_pkg::VAL_W-1:0]    value,
	input  wire logic                                last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mlp_pkg::SHIFT_W-1:0]         cfg_data,
	output logic                                     strobe,
	output logic [mlp_pkg::IDX_W-1:0]                class_index,
	output logic signed [mlp_pkg::SCORE_W-1:0]       best_score
);
	import mlp_pkg::*;

	localparam int HW_DEPTH = INPUT_COUNT * HIDDEN_COUNT;
	localparam int OW_DEPTH = CLASS_COUNT * HIDDEN_COUNT;
	localparam int HWA = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
	localparam int HBA = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
	localparam int OWA = (OW_DEPTH > 1) ? $clog2(OW_DEPTH) : 1;
	localparam int CW = $clog2(CLASS_COUNT);
	localparam int ACT_W = WEIGHT_BITS - 1;
	localparam int PROD_W = VAL_W + WEIGHT_BITS;
	localparam int LW = PROD_W + $clog2(HIDDEN_COUNT + 1) + 1;
	localparam logic [ACC_W-1:0] ACT_MAX = (ACC_W'(1) << ACT_W) - ACC_W'(1);
	localparam logic signed [63:0] SCORE_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SCORE_MIN = -64'sh0000_0000_8000_0000;

	logic [31:0] addr_ext;
	logic        accept;
	op_t         op_in;
	logic        hw_we, hb_we, ow_we, ob_we;

	logic [SHIFT_W-1:0] frac_q;
	logic signed [VAL_W-1:0] ob_q [CLASS_COUNT];

	seq_state_t state_q, state_n;
	logic [HBA-1:0] h_q, h_n;
	logic [CW-1:0]  c_q, c_n;
	logic [HWA-1:0] haddr_q, haddr_n;
	logic [OWA-1:0] oaddr_q, oaddr_n;
	logic           last_q;
	logic [PIX_W-1:0] pix_q;
	tag_t           iss;
	logic           h_end;

	logic [VAL_W-1:0] hw_rd, hb_rd, ow_rd;

	tag_t tag_s1, tag_s2, tag_s3;
	logic signed [VAL_W+PIX_W:0]  prod_s2;
	logic signed [VAL_W-1:0]      dat_s2;
	logic signed [PROD_W-1:0]     lprod_s3;

	logic [ACC_W-1:0] cell_q [HIDDEN_COUNT];
	logic [ACC_W-1:0] head, tail;
	logic signed [ACC_W:0] mac_sum, pre_act;
	logic [ACC_W-1:0] shifted;

	logic signed [LW-1:0] acc_q, acc_n, best_q;
	logic [IDX_W-1:0]     bestc_q, cls_s4;
	logic                 done_s4, final_s4, better;
	logic signed [63:0]   win64;

	assign addr_ext  = 32'(addr);
	assign accept    = start && !busy;
	assign op_in     = op_t'(op);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		hw_we = 1'b0;
		hb_we = 1'b0;
		ow_we = 1'b0;
		ob_we = 1'b0;
		if (accept) begin
			case (op_in)
				OP_HW:   hw_we = (addr_ext < 32'(HW_DEPTH));
				OP_HB:   hb_we = (addr_ext < 32'(HIDDEN_COUNT));
				OP_OW:   ow_we = (addr_ext < 32'(OW_DEPTH));
				OP_OB:   ob_we = (addr_ext < 32'(CLASS_COUNT));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frac_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_we) begin
			ob_q[addr_ext[CW-1:0]] <= value;
		end
		if (accept && op_in == OP_PIX) begin
			pix_q  <= value[PIX_W-1:0];
			last_q <= last;
		end
	end

	mlp_ram #(.WIDTH(VAL_W), .DEPTH(HW_DEPTH)) u_hw_ram (
		.clk(clk), .we(hw_we), .waddr(addr_ext[HWA-1:0]), .wdata(value),
		.raddr(haddr_q), .rdata(hw_rd)
	);
	mlp_ram #(.WIDTH(VAL_W), .DEPTH(HIDDEN_COUNT)) u_hb_ram (
		.clk(clk), .we(hb_we), .waddr(addr_ext[HBA-1:0]), .wdata(value),
		.raddr(h_q), .rdata(hb_rd)
	);
	mlp_ram #(.WIDTH(VAL_W), .DEPTH(OW_DEPTH)) u_ow_ram (
		.clk(clk), .we(ow_we), .waddr(addr_ext[OWA-1:0]), .wdata(value),
		.raddr(oaddr_q), .rdata(ow_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q     <= '0;
			c_q     <= '0;
			haddr_q <= '0;
			oaddr_q <= '0;
		end else begin
			state_q <= state_n;
			h_q     <= h_n;
			c_q     <= c_n;
			haddr_q <= haddr_n;
			oaddr_q <= oaddr_n;
		end
	end

	assign h_end = (h_q == HBA'(HIDDEN_COUNT - 1));

	always_comb begin
		state_n = state_q;
		h_n     = h_q;
		c_n     = c_q;
		haddr_n = haddr_q;
		oaddr_n = oaddr_q;
		iss     = '0;
		case (state_q)
			ST_IDLE: begin
				h_n = '0;
				if (accept && op_in == OP_PIX) begin
					if (addr_ext < 32'(INPUT_COUNT)) begin
						haddr_n = addr_ext[HWA-1:0];
						state_n = ST_PIX;
					end else if (last) begin
						state_n = ST_ACT;
					end
				end
			end
			ST_PIX: begin
				iss.v      = 1'b1;
				iss.kind   = PASS_PIX;
				iss.last_h = h_end;
				haddr_n    = haddr_q + HWA'(INPUT_COUNT);
				h_n        = h_q + HBA'(1);
				if (h_end) begin
					h_n     = '0;
					state_n = last_q ? ST_ACT : ST_DRAIN;
				end
			end
			ST_ACT: begin
				iss.v      = 1'b1;
				iss.kind   = PASS_ACT;
				iss.last_h = h_end;
				h_n        = h_q + HBA'(1);
				if (h_end) begin
					h_n     = '0;
					c_n     = '0;
					oaddr_n = '0;
					state_n = ST_LOGIT;
				end
			end
			ST_LOGIT: begin
				iss.v       = 1'b1;
				iss.kind    = PASS_LOGIT;
				iss.first_h = (h_q == '0);
				iss.last_h  = h_end;
				iss.final_c = (c_q == CW'(CLASS_COUNT - 1));
				iss.cls     = IDX_W'(c_q);
				oaddr_n     = oaddr_q + OWA'(1);
				h_n         = h_q + HBA'(1);
				if (h_end) begin
					h_n = '0;
					c_n = c_q + CW'(1);
					if (iss.final_c) begin
						state_n = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!tag_s1.v && !tag_s2.v && !tag_s3.v && !done_s4) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s3  <= '0;
			done_s4 <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			tag_s1  <= iss;
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
			done_s4 <= tag_s3.v && tag_s3.kind == PASS_LOGIT && tag_s3.last_h;
			strobe  <= done_s4 && final_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= $signed(hw_rd) * $signed({1'b0, pix_q});
		dat_s2   <= (tag_s1.kind == PASS_ACT) ? $signed(hb_rd) : $signed(ow_rd);
		lprod_s3 <= dat_s2 * $signed({1'b0, head[ACT_W-1:0]});
	end

	assign head    = cell_q[0];
	assign mac_sum = (ACC_W+1)'($signed(head)) + (ACC_W+1)'(prod_s2);
	assign pre_act = (ACC_W+1)'($signed(head)) + (ACC_W+1)'(dat_s2);
	assign shifted = pre_act[ACC_W-1:0] >> frac_q;

	always_comb begin
		tail = head;
		case (tag_s2.kind)
			PASS_PIX: begin
				if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
					tail = mac_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
				end else begin
					tail = mac_sum[ACC_W-1:0];
				end
			end
			PASS_ACT: begin
				if (pre_act[ACC_W]) begin
					tail = '0;
				end else if (shifted > ACT_MAX) begin
					tail = ACT_MAX;
				end else begin
					tail = shifted;
				end
			end
			PASS_LOGIT: tail = tag_s2.final_c ? '0 : head;
			default:    tail = head;
		endcase
	end

	for (genvar k = 0; k < HIDDEN_COUNT; k++) begin : g_ring
		mlp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(tag_s2.v),
			.d((k == HIDDEN_COUNT - 1) ? tail : cell_q[(k + 1) % HIDDEN_COUNT]),
			.q(cell_q[k])
		);
	end

	always_comb begin
		acc_n = (tag_s3.first_h ? LW'(ob_q[tag_s3.cls[CW-1:0]]) : acc_q) + LW'(lprod_s3);
	end

	assign better = (cls_s4 == '0) || (acc_q > best_q);
	assign win64  = better ? 64'(acc_q) : 64'(best_q);

	always_ff @(posedge clk) begin
		if (tag_s3.v && tag_s3.kind == PASS_LOGIT) begin
			acc_q    <= acc_n;
			cls_s4   <= tag_s3.cls;
			final_s4 <= tag_s3.final_c;
		end
		if (done_s4) begin
			if (better) begin
				best_q  <= acc_q;
				bestc_q <= cls_s4;
			end
			class_index <= better ? cls_s4 : bestc_q;
			if (win64 > SCORE_MAX) begin
				best_score <= SCORE_MAX[SCORE_W-1:0];
			end else if (win64 < SCORE_MIN) begin
				best_score <= SCORE_MIN[SCORE_W-1:0];
			end else begin
				best_score <= win64[SCORE_W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mlp_chk.sv */
`default_nettype none
module mlp_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [2:0] op,
	input wire logic       last,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic       strobe
);
	import mlp_pkg::*;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("result strobe held for two cycles");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result delivered while idle");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_PIX && last) |=> busy)
		else $error("last pixel transfer did not start the output layer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready) else $error("configuration transfer refused");
endmodule

bind mlp_two_layer_inference_core mlp_chk u_mlp_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .last(last),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .strobe(strobe)
);
`default_nettype wire

/* bench/tb_mlp_two_layer_inference_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_mlp_two_layer_inference_core;
	import mlp_pkg::*;

	localparam int N_IN    = 784;
	localparam int N_HID   = 100;
	localparam int N_CLS   = 10;
	localparam int N_PHASE = 4;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE  = 30;
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam logic [16:0] ADDR_TOP = 17'h1FFFF;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -ACC_HI - 1;

	typedef struct {
		logic [2:0]  op;
		logic [16:0] addr;
		logic [15:0] value;
		logic        last;
	} item_t;

	typedef struct {
		logic [IDX_W-1:0]   cls;
		logic [SCORE_W-1:0] score;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] op;
	logic [16:0] addr;
	logic signed [VAL_W-1:0] value;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [SHIFT_W-1:0] cfg_data;
	logic strobe;
	logic [IDX_W-1:0] class_index;
	logic signed [SCORE_W-1:0] best_score;

	mlp_two_layer_inference_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .addr(addr), .value(value), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.strobe(strobe), .class_index(class_index), .best_score(best_score)
	);

	logic signed [15:0] hid_w [0:N_IN*N_HID-1];
	logic signed [15:0] hid_b [0:N_HID-1];
	logic signed [15:0] out_w [0:N_CLS*N_HID-1];
	logic signed [15:0] out_b [0:N_CLS-1];
	longint hid_sum [0:N_HID-1];
	logic [SHIFT_W-1:0] shift_amt;
	verdict_t pending_verdicts[$];
	int n_errors;
	int cols[9] = '{0, 1, 2, 3, 4, 5, 6, 7, 783};

	item_t directed_rows[] = '{
		'{OP_SPARE_5, 17'd0, 16'h1234, 1'b1},
		'{OP_SPARE_6, ADDR_TOP, 16'hFFFF, 1'b0},
		'{OP_SPARE_7, 17'd5, 16'h0000, 1'b1},
		'{OP_HW, 17'd78400, 16'h7FFF, 1'b0},
		'{OP_HB, 17'd100, 16'h8000, 1'b1},
		'{OP_OW, 17'd1000, 16'h7FFF, 1'b0},
		'{OP_OB, ADDR_TOP, 16'h8000, 1'b0},
		'{OP_HW, 17'd783, 16'h7FFF, 1'b1},
		'{OP_HW, 17'd77616, 16'h8000, 1'b0},
		'{OP_HB, 17'd99, 16'h7FFF, 1'b0},
		'{OP_OW, 17'd999, 16'h8000, 1'b0},
		'{OP_OB, 17'd9, 16'h7FFF, 1'b0},
		'{OP_PIX, 17'd0, 16'h00FF, 1'b0},
		'{OP_PIX, 17'd783, 16'hFFFF, 1'b0},
		'{OP_PIX, 17'd1, 16'h0000, 1'b1},
		'{OP_PIX, 17'd784, 16'h00FF, 1'b1},
		'{OP_PIX, ADDR_TOP, 16'h7F80, 1'b0},
		'{OP_PIX, 17'd2, 16'hFF7F, 1'b1}
	};

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void classify_image();
		longint act [0:N_HID-1];
		longint s;
		longint logit;
		longint best;
		int best_c;
		verdict_t vd;
		best = 0;
		best_c = 0;
		for (int h = 0; h < N_HID; h++) begin
			s = hid_sum[h] + longint'(hid_b[h]);
			if (s < 0)
				s = 0;
			s = s >>> shift_amt;
			act[h] = clip(s, 0, 32767);
		end
		for (int c = 0; c < N_CLS; c++) begin
			logit = longint'(out_b[c]);
			for (int h = 0; h < N_HID; h++)
				logit += longint'(out_w[c*N_HID+h]) * act[h];
			if (c == 0 || logit > best) begin
				best = logit;
				best_c = c;
			end
		end
		vd.cls = IDX_W'(best_c);
		vd.score = SCORE_W'(clip(best, -64'sd2147483648, 64'sd2147483647));
		pending_verdicts.push_back(vd);
		for (int h = 0; h < N_HID; h++)
			hid_sum[h] = 0;
	endfunction

	function automatic void apply_item(item_t it);
		longint pix;
		case (it.op)
			OP_HW: if (it.addr < N_IN*N_HID) hid_w[it.addr] = it.value;
			OP_HB: if (it.addr < N_HID) hid_b[it.addr] = it.value;
			OP_OW: if (it.addr < N_CLS*N_HID) out_w[it.addr] = it.value;
			OP_OB: if (it.addr < N_CLS) out_b[it.addr] = it.value;
			OP_PIX: begin
				if (it.addr < N_IN) begin
					pix = longint'(it.value[7:0]);
					for (int h = 0; h < N_HID; h++)
						hid_sum[h] = clip(hid_sum[h] + longint'(hid_w[h*N_IN+it.addr]) * pix,
							ACC_LO, ACC_HI);
				end
				if (it.last)
					classify_image();
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= it.op;
		addr <= it.addr;
		value <= it.value;
		last <= it.last;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_item(it);
	endtask

	task automatic write_shift(logic [SHIFT_W-1:0] s);
		start <= 1'b0;
		wait (pending_verdicts.size() == 0);
		do @(posedge clk); while (busy);
		repeat (SETTLE) @(posedge clk);
		cfg_data <= s;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		shift_amt = s;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		int pick;
		it.value = 16'($urandom);
		it.last = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			it.op = OP_PIX;
			it.addr = 17'(cols[$urandom_range(0, 8)]);
			it.last = ($urandom_range(0, 7) == 0);
		end else if (pick < 65) begin
			it.op = OP_PIX;
			it.addr = 17'($urandom_range(N_IN, 131071));
			it.last = 1'($urandom_range(0, 1));
		end else if (pick < 72) begin
			it.op = OP_HW;
			it.addr = 17'($urandom_range(0, N_IN*N_HID-1));
		end else if (pick < 78) begin
			it.op = OP_HB;
			it.addr = 17'($urandom_range(0, N_HID-1));
		end else if (pick < 86) begin
			it.op = OP_OW;
			it.addr = 17'($urandom_range(0, N_CLS*N_HID-1));
		end else if (pick < 91) begin
			it.op = OP_OB;
			it.addr = 17'($urandom_range(0, N_CLS-1));
		end else if (pick < 96) begin
			it.op = 3'($urandom_range(0, 3));
			it.addr = 17'($urandom_range(N_IN*N_HID, 131071));
			it.last = 1'($urandom_range(0, 1));
		end else begin
			case ($urandom_range(0, 2))
				0: it.op = OP_SPARE_5;
				1: it.op = OP_SPARE_6;
				default: it.op = OP_SPARE_7;
			endcase
			it.addr = 17'($urandom);
			it.last = 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (strobe) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result class %0d score %0d", $time,
					class_index, best_score);
				n_errors++;
			end else begin
				if (class_index !== pending_verdicts[0].cls) begin
					$display("%0t: class_index expected %0d actual %0d", $time,
						pending_verdicts[0].cls, class_index);
					n_errors++;
				end
				if (best_score !== pending_verdicts[0].score) begin
					$display("%0t: best_score expected %0d actual %0d", $time,
						$signed(pending_verdicts[0].score), best_score);
					n_errors++;
				end
				void'(pending_verdicts.pop_front());
			end
		end
	end

	initial begin
		item_t it;
		n_errors = 0;
		shift_amt = SHIFT_RESET;
		for (int h = 0; h < N_HID; h++)
			hid_sum[h] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_HW;
		addr = '0;
		value = '0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every store entry that a pixel or a finished image reads is loaded first.
		for (int k = 0; k < 9; k++)
			for (int h = 0; h < N_HID; h++) begin
				it = '{OP_HW, 17'(h*N_IN+cols[k]), 16'($urandom), 1'b0};
				send_item(it);
			end
		for (int h = 0; h < N_HID; h++) begin
			it = '{OP_HB, 17'(h), 16'($urandom), 1'b0};
			send_item(it);
		end
		for (int j = 0; j < N_CLS*N_HID; j++) begin
			it = '{OP_OW, 17'(j), 16'($urandom), 1'b0};
			send_item(it);
		end
		for (int c = 0; c < N_CLS; c++) begin
			it = '{OP_OB, 17'(c), 16'($urandom), 1'b0};
			send_item(it);
		end

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int p = 0; p < N_PHASE; p++) begin
			case (p)
				0: write_shift(4'd15);
				1: write_shift(4'd0);
				2: write_shift(4'($urandom_range(1, 14)));
				default: write_shift(SHIFT_RESET);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item());
		end
		start <= 1'b0;

		wait (pending_verdicts.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (n_errors == 0 && pending_verdicts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
